// File: sv/csc_pkg.sv
// Shared types and constants for the clock replacement sector cache directory.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package csc_pkg;

   localparam int CACHE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(CACHE_ENTRIES);
   localparam int SECTOR_W      = 32;
   localparam int SLOT_W        = 6;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [SECTOR_W-1:0] sector_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic search;
      logic commit;
   } cmd_type;

endpackage

// File: sv/csc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module csc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/csc_ctrl.sv
// Sequencing controller for the sector cache directory: idle, search, update.
// Depends on csc_pkg.
`timescale 1ns / 1ps

module csc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output csc_pkg::cmd_type cmd
);

   import csc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy       = 1'b1;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SEARCH: cmd.search = 1'b1;
         ST_UPDATE: cmd.commit = 1'b1;
         default:   busy       = 1'b1;
      endcase
   end

endmodule

// File: sv/csc_dpath.sv
// Directory datapath: tag lanes, valid and reference bits, clock hand,
// search results, victim tag RAM and result registers. Depends on csc_pkg, csc_ram.
`timescale 1ns / 1ps

module csc_dpath (
   input  logic                clock,
   input  logic                reset,
   input  csc_pkg::cmd_type    cmd,
   input  csc_pkg::sector_type req_sector,
   output logic                rsp_strobe,
   output logic                rsp_hit,
   output csc_pkg::slot_type   rsp_slot,
   output logic                rsp_writeback,
   output csc_pkg::sector_type rsp_victim_sector
);

   import csc_pkg::*;

   sector_type                sector_ff;
   logic [CACHE_ENTRIES-1:0]  valid_ff,  valid_in;
   logic [CACHE_ENTRIES-1:0]  ref_ff,    ref_in;
   sector_type                tag_ff [CACHE_ENTRIES];
   idx_type                   hand_ff,   hand_in;

   // registered search results
   logic                      hit_ff;
   idx_type                   hit_idx_ff;
   logic                      full_ff;
   idx_type                   free_idx_ff;
   idx_type                   vict_idx_ff;
   logic                      wrap_ff;

   logic                      rsp_strobe_ff;
   logic                      rsp_hit_ff;
   slot_type                  rsp_slot_ff;
   logic                      rsp_wb_ff;
   sector_type                rsp_victim_ff;

   logic                      match_found;
   idx_type                   match_idx;
   logic                      any_free;
   idx_type                   free_idx;
   logic                      up_found;
   idx_type                   up_idx;
   logic                      any_zero;
   idx_type                   zero_idx;
   idx_type                   vict_idx;

   idx_type                   target;
   logic                      evict;
   logic                      lane_clr;
   sector_type                ram_rdata;

   // Parallel tag compare and priority searches, lowest index wins
   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      any_free    = 1'b0;
      free_idx    = '0;
      up_found    = 1'b0;
      up_idx      = '0;
      any_zero    = 1'b0;
      zero_idx    = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == sector_ff)) begin
            match_found = 1'b1;
            match_idx   = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (!ref_ff[i] && (IDX_W'(i) >= hand_ff)) begin
            up_found = 1'b1;
            up_idx   = IDX_W'(i);
         end
         if (!ref_ff[i]) begin
            any_zero = 1'b1;
            zero_idx = IDX_W'(i);
         end
      end
      // first clear bit from the hand; with every bit set, the hand itself
      if (up_found) begin
         vict_idx = up_idx;
      end else if (any_zero) begin
         vict_idx = zero_idx;
      end else begin
         vict_idx = hand_ff;
      end
   end

   assign evict  = !hit_ff && full_ff;
   assign target = hit_ff ? hit_idx_ff : (full_ff ? vict_idx_ff : free_idx_ff);

   always_comb begin
      valid_in = valid_ff;
      ref_in   = ref_ff;
      lane_clr = 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         // second chance: clear bits passed over from the hand up to the victim
         lane_clr = wrap_ff ? ((IDX_W'(i) >= hand_ff) || (IDX_W'(i) < vict_idx_ff))
                            : ((IDX_W'(i) >= hand_ff) && (IDX_W'(i) < vict_idx_ff));
         if (cmd.commit) begin
            if (evict && lane_clr) begin
               ref_in[i] = 1'b0;
            end
            if (IDX_W'(i) == target) begin
               valid_in[i] = 1'b1;
               ref_in[i]   = 1'b1;
            end
         end
      end
   end

   always_comb begin
      hand_in = hand_ff;
      if (cmd.commit && evict) begin
         hand_in = (vict_idx_ff == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : vict_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         ref_ff        <= '0;
         hand_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         ref_ff        <= ref_in;
         hand_ff       <= hand_in;
         rsp_strobe_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sector_ff <= req_sector;
      end
      if (cmd.search) begin
         hit_ff      <= match_found;
         hit_idx_ff  <= match_idx;
         full_ff     <= !any_free;
         free_idx_ff <= free_idx;
         vict_idx_ff <= vict_idx;
         wrap_ff     <= !up_found;
      end
      if (cmd.commit) begin
         rsp_hit_ff    <= hit_ff;
         rsp_slot_ff   <= SLOT_W'(target);
         rsp_wb_ff     <= evict;
         rsp_victim_ff <= evict ? ram_rdata : '0;
      end
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (cmd.commit && !hit_ff && (IDX_W'(i) == target)) begin
            tag_ff[i] <= sector_ff;
         end
      end
   end

   // Tag copy for reading out the victim word; read issued during the search
   csc_ram #(
      .WIDTH (SECTOR_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && !hit_ff),
      .wr_addr (target),
      .wr_data (sector_ff),
      .rd_addr (vict_idx),
      .rd_data (ram_rdata)
   );

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_writeback     = rsp_wb_ff;
   assign rsp_victim_sector = rsp_victim_ff;

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_writeback |-> rsp_victim_sector == '0)
      else $error("victim word not zero without write-back");

   a_wb_only_full: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && evict |-> (&valid_ff))
      else $error("eviction with a free slot left");

   a_hand_hold: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && evict) |=> $stable(hand_ff))
      else $error("clock hand moved without an eviction");

   a_target_set: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> valid_ff[$past(target)] && ref_ff[$past(target)])
      else $error("updated slot not left valid and referenced");

   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && hit_ff |=> rsp_strobe && rsp_hit && !rsp_writeback)
      else $error("hit reported with a write-back");

endmodule

// File: sv/clock_replacement_sector_cache.sv
// Sector cache directory with clock (second chance) replacement.
// A word is loaded, searched, then committed in the update state, which registers
// the result strobe. A new word is accepted only in idle, after the update state.
// Searches run across all tag lanes in parallel; the victim tag comes from a RAM.
// Reset (synchronous, active high) clears valid and reference bits, hand and strobe.
// Results cannot be stalled: each is shown for exactly one cycle.
`timescale 1ns / 1ps

module clock_replacement_sector_cache (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  csc_pkg::sector_type req_sector,
   output logic                rsp_strobe,
   output logic                rsp_hit,
   output csc_pkg::slot_type   rsp_slot,
   output logic                rsp_writeback,
   output csc_pkg::sector_type rsp_victim_sector
);

   import csc_pkg::*;

   cmd_type cmd;

   csc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   csc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_sector        (req_sector),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_writeback     (rsp_writeback),
      .rsp_victim_sector (rsp_victim_sector)
   );

endmodule
